// File: rtl/core/dsmt_pkg.sv
package dsmt_pkg;

    // angle range, degrees
    localparam int ANGLE_SPAN = 180;
    localparam int ANGLE_W    = 8;

    localparam int PULSE_MIN_NS   = 500000;
    localparam int PULSE_RANGE_NS = 2000000;
    localparam int PULSE_W        = 22;
    localparam int OFFSET_W       = 19;

    localparam int SETTLE_W  = 16;
    localparam int MS60_W    = 10;
    localparam int TIME_W    = 17;
    localparam int TRAVEL_W  = 13;

    // ceil(x / 60) taken as ((x + 59) * RECIP_60) >> SCALE_SHIFT, exact for x < 2^18
    localparam int    SCALE_SHIFT  = 24;
    localparam int    RECIP_60     = ((1 << SCALE_SHIFT) + 59) / 60;
    localparam int    MS_SCALED_W  = MS60_W + 19;
    localparam int    PROD_W       = ANGLE_W + MS_SCALED_W;
    localparam longint ROUND_TERM  = 59 * RECIP_60;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 19;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd30;
    localparam logic [MS60_W-1:0]   MS60_RESET   = 10'd200;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 19'd50000;
    localparam logic [MS_SCALED_W-1:0] MS_SCALED_RESET =
        MS_SCALED_W'(longint'(MS60_RESET) * longint'(RECIP_60));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETTLE    = 2'd0,
        CFG_MS60      = 2'd1,
        CFG_LEFT_OFF  = 2'd2,
        CFG_RIGHT_OFF = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        SEL_LEFT  = 2'd0,
        SEL_RIGHT = 2'd1,
        SEL_BOTH  = 2'd2
    } t_servo_sel;

    typedef logic [PULSE_W-1:0] t_pulse_tab [0:(1<<ANGLE_W)-1];

    function automatic t_pulse_tab f_build_pulse_tab();
        t_pulse_tab tab;
        for (int i = 0; i < (1 << ANGLE_W); i++) begin
            tab[i] = PULSE_W'(longint'(PULSE_MIN_NS)
                     + (longint'(i) * longint'(PULSE_RANGE_NS)) / ANGLE_SPAN);
        end
        return tab;
    endfunction

    // base pulse width for each angle, entries past the span are unused
    localparam t_pulse_tab PULSE_TAB = f_build_pulse_tab();

endpackage

// File: rtl/core/dsmt_travel.sv
module dsmt_travel (
    input  logic [dsmt_pkg::ANGLE_W-1:0]     i_from,
    input  logic [dsmt_pkg::ANGLE_W-1:0]     i_to,
    input  logic [dsmt_pkg::MS_SCALED_W-1:0] i_ms_scaled,
    output logic [dsmt_pkg::TRAVEL_W-1:0]    o_travel_ms
);

    logic [dsmt_pkg::ANGLE_W-1:0] w_diff;
    logic [dsmt_pkg::PROD_W-1:0]  w_prod;
    logic [dsmt_pkg::PROD_W-1:0]  w_sum;

    assign w_diff = (i_to > i_from) ? (i_to - i_from) : (i_from - i_to);

    // i_ms_scaled already carries the reciprocal of 60
    assign w_prod = {{dsmt_pkg::MS_SCALED_W{1'b0}}, w_diff}
                    * {{dsmt_pkg::ANGLE_W{1'b0}}, i_ms_scaled};
    assign w_sum  = w_prod + dsmt_pkg::PROD_W'(dsmt_pkg::ROUND_TERM);

    assign o_travel_ms = w_sum[dsmt_pkg::SCALE_SHIFT +: dsmt_pkg::TRAVEL_W];

endmodule

// File: rtl/core/dual_servo_move_timer.sv
// Two-servo angle controller with move-time estimation.
// Input stream: tuser = {servo_select[2:1], operation[0]}, tdata[9:0] = signed angle.
// A set command clamps the angle, updates the target(s), issues pulse widths,
// powers up and loads the move time; a tick counts one millisecond of motion.
// Output stream: one transaction per input transaction carrying the pulse
// widths, write flags, power and motion status and the loaded move time.
// Configuration: write enable, register index and data; a write takes effect at
// the next clock. The user must issue writes only while no transaction is in
// flight; the block does not enforce this. A transaction passes the input register,
// then the result register. Throughput: one transaction per cycle while the receiver
// accepts; the update is an angle-by-rate multiply per servo and a 17-bit compare.
// When the receiver stalls, the result register holds and the input register
// takes one more transaction; then s_axis_tready drops until the output moves.
// Reset (synchronous, active low) empties both registers, restores the register
// defaults and leaves both servos at angle 0 with power off.
module dual_servo_move_timer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [9:0] angle_deg, [15:10] zero
    input  logic [dsmt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] operation, [2:1] servo_select
    input  logic [dsmt_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] left_write, [22:1] left_pulse_ns, [23] right_write,
    // [45:24] right_pulse_ns, [46] power_on, [47] in_motion,
    // [64:48] move_time_ms, [71:65] zero
    output logic [dsmt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [dsmt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dsmt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW = dsmt_pkg::ANGLE_W;
    localparam int TW = dsmt_pkg::TIME_W;
    localparam int PW = dsmt_pkg::PULSE_W;

    // configuration
    logic [dsmt_pkg::SETTLE_W-1:0]    r_settle;
    logic [dsmt_pkg::MS_SCALED_W-1:0] r_ms_scaled;
    logic [dsmt_pkg::OFFSET_W-1:0]    r_left_off;
    logic [dsmt_pkg::OFFSET_W-1:0]    r_right_off;

    // input register
    logic        r_in_valid;
    logic        r_in_op;
    logic [1:0]  r_in_sel;
    logic [9:0]  r_in_angle;

    // servo state
    logic [AW-1:0] r_cur_l, r_cur_r, r_tgt_l, r_tgt_r;
    logic [TW-1:0] r_need, r_elapsed;
    logic          r_moving, r_power;

    logic [AW-1:0] n_cur_l, n_cur_r, n_tgt_l, n_tgt_r;
    logic [TW-1:0] n_need, n_elapsed;
    logic          n_moving, n_power;

    // result register
    logic                             r_out_valid;
    logic [dsmt_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic [dsmt_pkg::OUT_TDATA_W-1:0] n_out_data;

    logic          w_advance;
    logic          w_hit_l, w_hit_r, w_cmd;
    logic [AW-1:0] w_ang;
    logic [dsmt_pkg::TRAVEL_W-1:0] w_travel_l, w_travel_r, w_travel_max;
    logic [TW-1:0] w_elapsed_inc;
    logic          w_lw, w_rw;
    logic [PW-1:0] w_lp, w_rp;

    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle    <= dsmt_pkg::SETTLE_RESET;
            r_ms_scaled <= dsmt_pkg::MS_SCALED_RESET;
            r_left_off  <= dsmt_pkg::OFFSET_RESET;
            r_right_off <= dsmt_pkg::OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (dsmt_pkg::t_cfg_idx'(i_cfg_index))
                dsmt_pkg::CFG_SETTLE: begin
                    r_settle <= i_cfg_data[dsmt_pkg::SETTLE_W-1:0];
                end
                dsmt_pkg::CFG_MS60: begin
                    r_ms_scaled <= dsmt_pkg::MS_SCALED_W'(
                        {19'd0, i_cfg_data[dsmt_pkg::MS60_W-1:0]}
                        * dsmt_pkg::MS_SCALED_W'(dsmt_pkg::RECIP_60));
                end
                dsmt_pkg::CFG_LEFT_OFF: begin
                    r_left_off <= i_cfg_data;
                end
                dsmt_pkg::CFG_RIGHT_OFF: begin
                    r_right_off <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_op    <= s_axis_tuser[0];
            r_in_sel   <= s_axis_tuser[2:1];
            r_in_angle <= s_axis_tdata[9:0];
        end
    end

    // clamp the signed request to 0..span
    always_comb begin
        if (r_in_angle[9]) begin
            w_ang = '0;
        end else if (r_in_angle[8:0] > 9'(dsmt_pkg::ANGLE_SPAN)) begin
            w_ang = AW'(dsmt_pkg::ANGLE_SPAN);
        end else begin
            w_ang = r_in_angle[AW-1:0];
        end
    end

    always_comb begin
        w_hit_l = 1'b0;
        w_hit_r = 1'b0;
        w_cmd   = 1'b0;
        if (dsmt_pkg::t_op'(r_in_op) == dsmt_pkg::OP_SET) begin
            case (dsmt_pkg::t_servo_sel'(r_in_sel))
                dsmt_pkg::SEL_LEFT: begin
                    w_hit_l = 1'b1;
                    w_cmd   = 1'b1;
                end
                dsmt_pkg::SEL_RIGHT: begin
                    w_hit_r = 1'b1;
                    w_cmd   = 1'b1;
                end
                dsmt_pkg::SEL_BOTH: begin
                    w_hit_l = 1'b1;
                    w_hit_r = 1'b1;
                    w_cmd   = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign n_tgt_l = w_hit_l ? w_ang : r_tgt_l;
    assign n_tgt_r = w_hit_r ? w_ang : r_tgt_r;

    dsmt_travel u_travel_l (
        .i_from      (r_cur_l),
        .i_to        (n_tgt_l),
        .i_ms_scaled (r_ms_scaled),
        .o_travel_ms (w_travel_l)
    );

    dsmt_travel u_travel_r (
        .i_from      (r_cur_r),
        .i_to        (n_tgt_r),
        .i_ms_scaled (r_ms_scaled),
        .o_travel_ms (w_travel_r)
    );

    assign w_travel_max  = (w_travel_l > w_travel_r) ? w_travel_l : w_travel_r;
    assign w_elapsed_inc = (r_elapsed != {TW{1'b1}}) ? (r_elapsed + 1'b1) : r_elapsed;

    assign w_lw = w_hit_l;
    assign w_rw = w_hit_r;
    assign w_lp = w_hit_l
        ? (dsmt_pkg::PULSE_TAB[w_ang] + PW'(r_left_off)) : '0;
    assign w_rp = w_hit_r
        ? (dsmt_pkg::PULSE_TAB[AW'(dsmt_pkg::ANGLE_SPAN) - w_ang] + PW'(r_right_off)) : '0;

    always_comb begin
        n_cur_l   = r_cur_l;
        n_cur_r   = r_cur_r;
        n_need    = r_need;
        n_elapsed = r_elapsed;
        n_moving  = r_moving;
        n_power   = r_power;
        if (w_cmd) begin
            n_need    = TW'(w_travel_max) + TW'(r_settle);
            n_elapsed = '0;
            n_moving  = 1'b1;
            n_power   = 1'b1;
        end else if (dsmt_pkg::t_op'(r_in_op) == dsmt_pkg::OP_TICK && r_moving) begin
            n_elapsed = w_elapsed_inc;
            // move time reached: servos are where they were sent
            if (w_elapsed_inc >= r_need) begin
                n_cur_l  = r_tgt_l;
                n_cur_r  = r_tgt_r;
                n_moving = 1'b0;
                n_power  = 1'b0;
            end
        end
    end

    always_comb begin
        n_out_data = {7'd0, n_need, n_moving, n_power, w_rp, w_rw, w_lp, w_lw};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_l   <= '0;
            r_cur_r   <= '0;
            r_tgt_l   <= '0;
            r_tgt_r   <= '0;
            r_need    <= '0;
            r_elapsed <= '0;
            r_moving  <= 1'b0;
            r_power   <= 1'b0;
        end else if (w_advance) begin
            r_cur_l   <= n_cur_l;
            r_cur_r   <= n_cur_r;
            r_tgt_l   <= n_tgt_l;
            r_tgt_r   <= n_tgt_r;
            r_need    <= n_need;
            r_elapsed <= n_elapsed;
            r_moving  <= n_moving;
            r_power   <= n_power;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// File: tb/sv/dual_servo_move_timer_tb.sv
`timescale 1ns / 100ps

module dual_servo_move_timer_tb;

    localparam logic [1:0] SEL_NONE    = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         HOLD_LEN    = 300;

    typedef struct packed {
        dsmt_pkg::t_op op;
        logic [1:0]    sel;
        logic [9:0]    ang;
    } t_servo_cmd;

    typedef struct packed {
        logic                         l_wr;
        logic [dsmt_pkg::PULSE_W-1:0] l_pulse;
        logic                         r_wr;
        logic [dsmt_pkg::PULSE_W-1:0] r_pulse;
        logic                         pwr;
        logic                         mot;
        logic [dsmt_pkg::TIME_W-1:0]  move_ms;
    } t_servo_status;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [dsmt_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [dsmt_pkg::IN_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [dsmt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                              i_cfg_we = 1'b0;
    logic [dsmt_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [dsmt_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    dual_servo_move_timer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow of the block's registers and servo state
    logic [dsmt_pkg::SETTLE_W-1:0] settle_r;
    logic [dsmt_pkg::MS60_W-1:0]   ms60_r;
    logic [dsmt_pkg::OFFSET_W-1:0] off_l_r;
    logic [dsmt_pkg::OFFSET_W-1:0] off_r_r;
    int                            cur_l, cur_r, tgt_l, tgt_r;
    logic [dsmt_pkg::TIME_W-1:0]   need_ms;
    logic [dsmt_pkg::TIME_W-1:0]   elapsed_ms;
    logic                          moving, powered;

    t_servo_cmd    cmd_q[$];
    t_servo_status want_status_q[$];
    t_servo_cmd    drv_cmd;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int bad_results = 0;
    int cycle_cnt = 0;
    int hold_cnt = 0;
    logic hold_arm = 1'b0;

    function automatic int pulse_width(input int a);
        return dsmt_pkg::PULSE_MIN_NS
               + (a * dsmt_pkg::PULSE_RANGE_NS) / dsmt_pkg::ANGLE_SPAN;
    endfunction

    function automatic int travel_time(input int from_a, input int to_a);
        int d;
        d = (to_a > from_a) ? (to_a - from_a) : (from_a - to_a);
        return (d * int'(ms60_r) + 59) / 60;
    endfunction

    task automatic servo_predict(input t_servo_cmd c, output t_servo_status r);
        int a, tl, tr, need;
        r = '0;
        if (c.op == dsmt_pkg::OP_SET) begin
            if (c.sel != SEL_NONE) begin
                if (c.ang[9])
                    a = 0;
                else if (c.ang > dsmt_pkg::ANGLE_SPAN)
                    a = dsmt_pkg::ANGLE_SPAN;
                else
                    a = int'(c.ang);
                if (c.sel == dsmt_pkg::SEL_LEFT || c.sel == dsmt_pkg::SEL_BOTH) begin
                    tgt_l     = a;
                    r.l_wr    = 1'b1;
                    r.l_pulse = dsmt_pkg::PULSE_W'(pulse_width(a) + int'(off_l_r));
                end
                if (c.sel == dsmt_pkg::SEL_RIGHT || c.sel == dsmt_pkg::SEL_BOTH) begin
                    tgt_r     = a;
                    r.r_wr    = 1'b1;
                    // right servo is mounted mirrored
                    r.r_pulse = dsmt_pkg::PULSE_W'(pulse_width(dsmt_pkg::ANGLE_SPAN - a)
                                                   + int'(off_r_r));
                end
                tl = travel_time(cur_l, tgt_l);
                tr = travel_time(cur_r, tgt_r);
                need = ((tl > tr) ? tl : tr) + int'(settle_r);
                need_ms    = dsmt_pkg::TIME_W'(need);
                elapsed_ms = '0;
                moving     = 1'b1;
                powered    = 1'b1;
            end
        end else if (moving) begin
            if (elapsed_ms != '1)
                elapsed_ms = elapsed_ms + 1'b1;
            if (elapsed_ms >= need_ms) begin
                cur_l   = tgt_l;
                cur_r   = tgt_r;
                powered = 1'b0;
                moving  = 1'b0;
            end
        end
        r.pwr     = powered;
        r.mot     = moving;
        r.move_ms = need_ms;
    endtask

    always @(posedge i_clk) begin : driver
        t_servo_status r;
        logic          give;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                servo_predict(drv_cmd, r);
                want_status_q.push_back(r);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                give = (cmd_q.size() != 0) && ($urandom_range(0, 99) >= snd_idle_pct);
                if (give) begin
                    drv_cmd = cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'd0, drv_cmd.ang};
                    s_axis_tuser  <= {drv_cmd.sel, drv_cmd.op};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver stall so the input side backs up
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_cnt <= 0;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        else if (hold_arm)
            hold_cnt <= HOLD_LEN;
    end

    always @(posedge i_clk) begin : monitor
        t_servo_status got, w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.l_wr    = m_axis_tdata[0];
                got.l_pulse = m_axis_tdata[22:1];
                got.r_wr    = m_axis_tdata[23];
                got.r_pulse = m_axis_tdata[45:24];
                got.pwr     = m_axis_tdata[46];
                got.mot     = m_axis_tdata[47];
                got.move_ms = m_axis_tdata[64:48];
                if (want_status_q.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result transaction: tdata=%h", m_axis_tdata);
                end else begin
                    w = want_status_q.pop_front();
                    if (got.l_wr !== w.l_wr || got.l_pulse !== w.l_pulse
                        || got.r_wr !== w.r_wr || got.r_pulse !== w.r_pulse
                        || got.pwr !== w.pwr || got.mot !== w.mot
                        || got.move_ms !== w.move_ms) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("mismatch exp: lw=%0d lp=%0d rw=%0d rp=%0d pwr=%0d mot=%0d ms=%0d",
                                     w.l_wr, w.l_pulse, w.r_wr, w.r_pulse,
                                     w.pwr, w.mot, w.move_ms);
                            $display("         act: lw=%0d lp=%0d rw=%0d rp=%0d pwr=%0d mot=%0d ms=%0d",
                                     got.l_wr, got.l_pulse, got.r_wr, got.r_pulse,
                                     got.pwr, got.mot, got.move_ms);
                        end
                    end
                end
            end
            if (hold_cnt != 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic queue_cmd(input dsmt_pkg::t_op op, input logic [1:0] sel,
                             input logic [9:0] ang);
        t_servo_cmd c;
        c.op  = op;
        c.sel = sel;
        c.ang = ang;
        cmd_q.push_back(c);
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (cmd_q.size() != 0 || s_axis_tvalid || want_status_q.size() != 0)
            @(negedge i_clk);
    endtask

    // all four registers back to back, we drops after the last one
    task automatic write_regs(input logic [dsmt_pkg::CFG_DATA_W-1:0] settle,
                              input logic [dsmt_pkg::CFG_DATA_W-1:0] ms60,
                              input logic [dsmt_pkg::CFG_DATA_W-1:0] off_l,
                              input logic [dsmt_pkg::CFG_DATA_W-1:0] off_r);
        logic [dsmt_pkg::CFG_DATA_W-1:0] vals [4];
        dsmt_pkg::t_cfg_idx              idx;
        vals[0] = settle;
        vals[1] = ms60;
        vals[2] = off_l;
        vals[3] = off_r;
        for (int i = 0; i < 4; i++) begin
            idx = dsmt_pkg::t_cfg_idx'(i);
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[i];
            case (idx)
                dsmt_pkg::CFG_SETTLE:    settle_r = vals[i][dsmt_pkg::SETTLE_W-1:0];
                dsmt_pkg::CFG_MS60:      ms60_r   = vals[i][dsmt_pkg::MS60_W-1:0];
                dsmt_pkg::CFG_LEFT_OFF:  off_l_r  = vals[i][dsmt_pkg::OFFSET_W-1:0];
                dsmt_pkg::CFG_RIGHT_OFF: off_r_r  = vals[i][dsmt_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [9:0] rand_angle();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            return 10'(-int'($urandom_range(1, 512)));
        else if (pick < 4)
            return 10'($urandom_range(181, 511));
        else if (pick == 4)
            return ($urandom_range(0, 1) != 0) ? 10'd0 : 10'(dsmt_pkg::ANGLE_SPAN);
        else
            return 10'($urandom_range(0, dsmt_pkg::ANGLE_SPAN));
    endfunction

    // mostly a set command followed by a run of ticks, some plain noise
    task automatic make_traffic(input int n_items, input int burst_cap);
        int         made, burst;
        logic [1:0] sel;
        made = 0;
        while (made < n_items) begin
            if ($urandom_range(0, 99) < 8) begin
                queue_cmd(dsmt_pkg::t_op'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                          10'($urandom));
                made++;
            end else begin
                sel = ($urandom_range(0, 19) == 0) ? SEL_NONE : 2'($urandom_range(0, 2));
                queue_cmd(dsmt_pkg::OP_SET, sel, rand_angle());
                if (sel != SEL_NONE)
                    made++;
                burst = $urandom_range(0, burst_cap);
                for (int i = 0; i < burst; i++)
                    queue_cmd(dsmt_pkg::OP_TICK, 2'($urandom_range(0, 3)), 10'($urandom));
                made += burst;
            end
        end
    endtask

    task automatic next_phase();
        wait_idle();
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        settle_r   = dsmt_pkg::SETTLE_RESET;
        ms60_r     = dsmt_pkg::MS60_RESET;
        off_l_r    = dsmt_pkg::OFFSET_RESET;
        off_r_r    = dsmt_pkg::OFFSET_RESET;
        cur_l      = 0;
        cur_r      = 0;
        tgt_l      = 0;
        tgt_r      = 0;
        need_ms    = '0;
        elapsed_ms = '0;
        moving     = 1'b0;
        powered    = 1'b0;

        snd_idle_pct = 6;
        rcv_idle_pct = 84;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults after reset
        queue_cmd(dsmt_pkg::OP_TICK, SEL_NONE, 10'h3FF);
        queue_cmd(dsmt_pkg::OP_SET, SEL_NONE, 10'd100);
        queue_cmd(dsmt_pkg::OP_SET, dsmt_pkg::SEL_BOTH, 10'd0);
        queue_cmd(dsmt_pkg::OP_TICK, dsmt_pkg::SEL_BOTH, 10'h200);
        queue_cmd(dsmt_pkg::OP_TICK, dsmt_pkg::SEL_LEFT, 10'd0);

        next_phase();
        write_regs(19'd0, 19'd1, 19'd0, 19'd500000);
        // zero move time, first tick finishes
        queue_cmd(dsmt_pkg::OP_SET, dsmt_pkg::SEL_BOTH, 10'd0);
        queue_cmd(dsmt_pkg::OP_TICK, dsmt_pkg::SEL_RIGHT, 10'd5);
        // over-range clamps to the full span
        queue_cmd(dsmt_pkg::OP_SET, dsmt_pkg::SEL_LEFT, 10'd511);
        repeat (3) queue_cmd(dsmt_pkg::OP_TICK, dsmt_pkg::SEL_LEFT, 10'h155);
        // most negative angle clamps to zero
        queue_cmd(dsmt_pkg::OP_SET, dsmt_pkg::SEL_RIGHT, 10'h200);
        queue_cmd(dsmt_pkg::OP_TICK, SEL_NONE, 10'h2AA);
        queue_cmd(dsmt_pkg::OP_SET, dsmt_pkg::SEL_BOTH, 10'd181);
        // a new command restarts timing mid-move
        queue_cmd(dsmt_pkg::OP_SET, dsmt_pkg::SEL_RIGHT, 10'd1);
        repeat (3) queue_cmd(dsmt_pkg::OP_TICK, dsmt_pkg::SEL_BOTH, 10'd0);
        queue_cmd(dsmt_pkg::OP_SET, dsmt_pkg::SEL_LEFT, 10'd60);
        repeat (2) queue_cmd(dsmt_pkg::OP_TICK, dsmt_pkg::SEL_LEFT, 10'd60);
        make_traffic(500, 6);

        next_phase();
        write_regs(19'd65535, 19'd1000, 19'd500000, 19'd0);
        make_traffic(300, 40);

        next_phase();
        snd_idle_pct = 84;
        rcv_idle_pct = 6;
        // zero travel rate, only the settle time counts
        write_regs(19'($urandom_range(0, 20)), 19'd0,
                   19'($urandom_range(0, 500000)), 19'($urandom_range(0, 500000)));
        make_traffic(400, 25);

        next_phase();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        // upper data bits beyond the register width are dropped
        write_regs(19'(($urandom_range(0, 7) << 16) | $urandom_range(0, 20)),
                   19'(($urandom_range(0, 511) << 10) | $urandom_range(1, 40)),
                   19'($urandom_range(0, 500000)), 19'($urandom_range(0, 500000)));
        make_traffic(400, int'(settle_r) + 3 * int'(ms60_r) + 3);

        next_phase();
        write_regs(19'd30, 19'd20, 19'($urandom_range(0, 500000)),
                   19'($urandom_range(0, 500000)));
        make_traffic(400, 100);
        @(posedge i_clk);
        hold_arm <= 1'b1;
        @(posedge i_clk);
        hold_arm <= 1'b0;

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (bad_results == 0 && want_status_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
